[rtl/hav_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Haversine distance package
// Fixed-point formats, pipeline depths and CORDIC rotation table.
// ----------------------------------------------------------------------------
package hav_pkg;

    localparam int CordicStages = 24;
    localparam int StageW       = 5;
    localparam int AngW         = 34;
    localparam int SqrtW        = 62;
    localparam int SqrtSteps    = 31;
    localparam int SqrtTop      = 60;
    localparam int NegDepth     = 3 + CordicStages;
    localparam int PipeDepth    = 2 * CordicStages + 40;

    typedef logic signed [AngW-1:0] t_ang;

    localparam logic [31:0] PiQ30       = 32'd3373259426;
    localparam logic [31:0] HalfTurnE7  = 32'd1800000000;
    localparam logic [31:0] FullTurnE7  = 32'd3600000000;
    localparam logic [31:0] RecipHalf   = 32'((64'd3373259426 << 30) / 64'd1800000000);
    localparam logic [31:0] RecipFull   = 32'((64'd3373259426 << 30) / 64'd3600000000);
    localparam t_ang        InvGainQ30  = 34'sd652032874;
    localparam logic [30:0] OneQ30      = 31'd1073741824;
    localparam logic [22:0] RadiusReset = 23'd6371000;
    localparam logic [30:0] DistMax     = 31'd2147483647;
    localparam logic [62:0] RoundHalf   = 63'd536870912;

    localparam logic signed [34:0] HalfTurnS    = 35'sd1800000000;
    localparam logic signed [34:0] FullTurnS    = 35'sd3600000000;
    localparam logic signed [34:0] QuarterTurnS = 35'sd900000000;

    localparam logic [31:0] AtanQ30 [32] = '{
        32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76,
        32'h01FFD55B, 32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD,
        32'h000FFFFF, 32'h0007FFFF, 32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF,
        32'h00007FFF, 32'h00003FFF, 32'h00001FFF, 32'h00000FFF, 32'h000007FF,
        32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F, 32'h0000003F,
        32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
        32'h00000001, 32'h00000000
    };

endpackage
`default_nettype wire

[rtl/hav_rad.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Degree-to-radian converter
// Three-stage round(|v| * pi * 2^30 / D) by reciprocal estimate and correction.
// ----------------------------------------------------------------------------
module hav_rad import hav_pkg::*; (
    input  wire logic               i_clk,
    input  wire logic               i_en,
    input  wire logic               i_half,
    input  wire logic signed [31:0] i_v,
    output t_ang                    o_z
);
    logic [30:0] w_mag;
    logic [31:0] w_den;
    logic [31:0] w_recip;
    logic [63:0] n_p;
    logic [62:0] n_pm;
    logic [63:0] r_p1, r_p2;
    logic [62:0] r_pm;
    logic [31:0] r_den1, r_den2;
    logic        r_neg1, r_neg2;
    logic [31:0] w_q0;
    logic [31:0] r_q0;
    logic [63:0] r_m2;
    logic [63:0] w_rem;
    logic [63:0] w_d1, w_d2, w_d3;
    logic [1:0]  w_cnt;
    logic [32:0] w_q;
    t_ang        r_z;

    assign w_mag   = i_v[31] ? 31'(-i_v) : 31'(i_v);
    assign w_den   = i_half ? HalfTurnE7 : FullTurnE7;
    assign w_recip = i_half ? RecipHalf : RecipFull;
    assign n_p     = 64'(63'(w_mag) * 63'(PiQ30)) + 64'(w_den >> 1);
    assign n_pm    = 63'(w_mag) * 63'(w_recip);

    assign w_q0 = 32'(r_pm >> 30);

    assign w_rem = r_p2 - r_m2;
    assign w_d1  = 64'(r_den2);
    assign w_d2  = 64'(r_den2) << 1;
    assign w_d3  = w_d1 + w_d2;
    assign w_cnt = 2'(w_rem >= w_d1) + 2'(w_rem >= w_d2) + 2'(w_rem >= w_d3);
    assign w_q   = 33'(r_q0) + 33'(w_cnt);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p1   <= n_p;
            r_pm   <= n_pm;
            r_den1 <= w_den;
            r_neg1 <= i_v[31];
            r_q0   <= w_q0;
            r_m2   <= 64'(w_q0) * 64'(r_den1);
            r_p2   <= r_p1;
            r_den2 <= r_den1;
            r_neg2 <= r_neg1;
            r_z    <= r_neg2 ? -t_ang'(w_q) : t_ang'(w_q);
        end
    end

    assign o_z = r_z;

endmodule
`default_nettype wire

[rtl/hav_rot_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CORDIC rotation cell
// One micro-rotation towards z = 0, registered.
// ----------------------------------------------------------------------------
module hav_rot_cell import hav_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [StageW-1:0] i_stage,
    input  wire t_ang              i_x,
    input  wire t_ang              i_y,
    input  wire t_ang              i_z,
    output t_ang                   o_x,
    output t_ang                   o_y,
    output t_ang                   o_z
);
    t_ang w_xs, w_ys, w_at;
    t_ang r_x, r_y, r_z;

    assign w_xs = i_x >>> i_stage;
    assign w_ys = i_y >>> i_stage;
    assign w_at = t_ang'(AtanQ30[i_stage]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_z[AngW-1]) begin
                r_x <= i_x - w_ys;
                r_y <= i_y + w_xs;
                r_z <= i_z - w_at;
            end else begin
                r_x <= i_x + w_ys;
                r_y <= i_y - w_xs;
                r_z <= i_z + w_at;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule
`default_nettype wire

[rtl/hav_sqrt_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Square-root digit cell
// One result bit of the digit-by-digit integer square root, registered.
// ----------------------------------------------------------------------------
module hav_sqrt_cell import hav_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [StageW-1:0] i_stage,
    input  wire logic [SqrtW-1:0]  i_n,
    input  wire logic [SqrtW-1:0]  i_r,
    output logic [SqrtW-1:0]       o_n,
    output logic [SqrtW-1:0]       o_r
);
    logic [5:0]       w_sh;
    logic [SqrtW-1:0] w_b, w_trial;
    logic [SqrtW-1:0] r_n, r_r;

    assign w_sh    = 6'(SqrtTop) - {i_stage, 1'b0};
    assign w_b     = SqrtW'(1) << w_sh;
    assign w_trial = i_r + w_b;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (i_n >= w_trial) begin
                r_n <= i_n - w_trial;
                r_r <= (i_r >> 1) + w_b;
            end else begin
                r_n <= i_n;
                r_r <= i_r >> 1;
            end
        end
    end

    assign o_n = r_n;
    assign o_r = r_r;

endmodule
`default_nettype wire

[rtl/hav_vec_cell.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// CORDIC vectoring cell
// One micro-rotation towards y = 0, accumulating the angle, registered.
// ----------------------------------------------------------------------------
module hav_vec_cell import hav_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_en,
    input  wire logic [StageW-1:0] i_stage,
    input  wire t_ang              i_x,
    input  wire t_ang              i_y,
    input  wire t_ang              i_z,
    output t_ang                   o_x,
    output t_ang                   o_y,
    output t_ang                   o_z
);
    t_ang w_xs, w_ys, w_at;
    t_ang r_x, r_y, r_z;

    assign w_xs = i_x >>> i_stage;
    assign w_ys = i_y >>> i_stage;
    assign w_at = t_ang'(AtanQ30[i_stage]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (!i_y[AngW-1]) begin
                r_x <= i_x + w_ys;
                r_y <= i_y - w_xs;
                r_z <= i_z + w_at;
            end else begin
                r_x <= i_x - w_ys;
                r_y <= i_y + w_xs;
                r_z <= i_z - w_at;
            end
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;
    assign o_z = r_z;

endmodule
`default_nettype wire

[rtl/haversine_distance.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Haversine great-circle distance
// Two positions in 1e-7 degree in, distance in centimetres out.
//
//   channel   direction  tdata (low bit up)                          width
//   s_axis    in         start_lat, start_lon, end_lat, end_lon      128
//   m_axis    out        distance_cm                                 32
//   cfg       in         sphere_radius_m                             23
//
// One request per cycle while the result is not stalled; the path runs through
// the two CORDIC chains and the 31-cell square-root chain.
// Reset clears the valid chain and loads the default radius.
// A stalled result holds the whole pipeline; nothing is dropped.
// ----------------------------------------------------------------------------
module haversine_distance import hav_pkg::*; (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    input  wire logic         i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  wire logic [127:0] i_s_axis_tdata,  // start_lat, start_lon, end_lat, end_lon
    output logic              o_m_axis_tvalid,
    input  wire logic         i_m_axis_tready,
    output logic [31:0]       o_m_axis_tdata,  // distance_cm
    input  wire logic         i_cfg_valid,
    output logic              o_cfg_ready,
    input  wire logic [22:0]  i_cfg_data       // sphere_radius_m
);
    logic                 w_en;
    logic [PipeDepth-1:0] r_vld;
    logic [22:0]          r_radius;
    logic [29:0]          r_rad_cm;

    logic signed [30:0] w_lat1, w_lat2;
    logic signed [31:0] w_lon1, w_lon2;
    logic signed [34:0] w_dlat, w_dlon, w_dlat_r, w_dlon_r;
    logic signed [34:0] w_l1, w_l2, w_l1f, w_l2f;
    logic [1:0]         w_neg;
    logic signed [31:0] r_rin [4];
    logic [1:0]         r_neg_a;
    logic [1:0]         r_negd [NegDepth];

    t_ang w_rz0 [4];
    t_ang w_rx [4][CordicStages+1];
    t_ang w_ry [4][CordicStages+1];
    t_ang w_rz [4][CordicStages+1];

    t_ang                    w_c1, w_c2;
    logic signed [2*AngW-1:0] w_sq1, w_sq2, w_ccp, w_mp;
    t_ang                    r_t1, r_t2, r_cc, r_t1b, r_m;
    logic signed [AngW:0]    w_sum;
    logic [30:0]             r_a;

    logic [SqrtW-1:0] w_sn [2][SqrtSteps+1];
    logic [SqrtW-1:0] w_sr [2][SqrtSteps+1];

    t_ang w_vx [CordicStages+1];
    t_ang w_vy [CordicStages+1];
    t_ang w_vz [CordicStages+1];

    logic [31:0] w_c;
    logic [61:0] r_prod;
    logic [62:0] w_rnd;
    logic [32:0] w_d;
    logic [30:0] r_dist;

    assign w_en            = !r_vld[PipeDepth-1] || i_m_axis_tready;
    assign o_s_axis_tready = w_en;
    assign o_m_axis_tvalid = r_vld[PipeDepth-1];
    assign o_m_axis_tdata  = {1'b0, r_dist};
    assign o_cfg_ready     = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_radius <= RadiusReset;
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[PipeDepth-2:0], i_s_axis_tvalid};
            end
            if (i_cfg_valid) begin
                r_radius <= i_cfg_data;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rad_cm <= 30'(r_radius) * 30'd100;
    end

    // reduce differences into a half turn, fold latitudes past the pole
    assign w_lat1 = $signed(i_s_axis_tdata[30:0]);
    assign w_lon1 = $signed(i_s_axis_tdata[62:31]);
    assign w_lat2 = $signed(i_s_axis_tdata[93:63]);
    assign w_lon2 = $signed(i_s_axis_tdata[125:94]);
    assign w_dlat = 35'(w_lat2) - 35'(w_lat1);
    assign w_dlon = 35'(w_lon2) - 35'(w_lon1);
    assign w_l1   = 35'(w_lat1);
    assign w_l2   = 35'(w_lat2);

    always_comb begin
        w_dlat_r = w_dlat;
        if (w_dlat >= HalfTurnS) begin
            w_dlat_r = w_dlat - FullTurnS;
        end else if (w_dlat < -HalfTurnS) begin
            w_dlat_r = w_dlat + FullTurnS;
        end
        w_dlon_r = w_dlon;
        if (w_dlon >= HalfTurnS) begin
            w_dlon_r = w_dlon - FullTurnS;
        end else if (w_dlon < -HalfTurnS) begin
            w_dlon_r = w_dlon + FullTurnS;
        end
        w_l1f = w_l1;
        w_neg = 2'b00;
        if (w_l1 > QuarterTurnS) begin
            w_l1f    = HalfTurnS - w_l1;
            w_neg[0] = 1'b1;
        end else if (w_l1 < -QuarterTurnS) begin
            w_l1f    = -HalfTurnS - w_l1;
            w_neg[0] = 1'b1;
        end
        w_l2f = w_l2;
        if (w_l2 > QuarterTurnS) begin
            w_l2f    = HalfTurnS - w_l2;
            w_neg[1] = 1'b1;
        end else if (w_l2 < -QuarterTurnS) begin
            w_l2f    = -HalfTurnS - w_l2;
            w_neg[1] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rin[0]  <= 32'(w_dlat_r);
            r_rin[1]  <= 32'(w_dlon_r);
            r_rin[2]  <= 32'(w_l1f);
            r_rin[3]  <= 32'(w_l2f);
            r_neg_a   <= w_neg;
            r_negd[0] <= r_neg_a;
            for (int k = 1; k < NegDepth; k++) begin
                r_negd[k] <= r_negd[k-1];
            end
        end
    end

    // lanes: half dlat, half dlon, lat1, lat2
    for (genvar l = 0; l < 4; l++) begin : g_lane
        hav_rad u_rad (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_half(l >= 2),
            .i_v   (r_rin[l]),
            .o_z   (w_rz0[l])
        );
        assign w_rx[l][0] = InvGainQ30;
        assign w_ry[l][0] = '0;
        assign w_rz[l][0] = w_rz0[l];
        for (genvar k = 0; k < CordicStages; k++) begin : g_rot
            hav_rot_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_stage(StageW'(k)),
                .i_x    (w_rx[l][k]),
                .i_y    (w_ry[l][k]),
                .i_z    (w_rz[l][k]),
                .o_x    (w_rx[l][k+1]),
                .o_y    (w_ry[l][k+1]),
                .o_z    (w_rz[l][k+1])
            );
        end
    end

    // form a = sin^2(dlat/2) + cos1*cos2*sin^2(dlon/2)
    assign w_c1  = r_negd[NegDepth-1][0] ? -w_rx[2][CordicStages] : w_rx[2][CordicStages];
    assign w_c2  = r_negd[NegDepth-1][1] ? -w_rx[3][CordicStages] : w_rx[3][CordicStages];
    assign w_sq1 = w_ry[0][CordicStages] * w_ry[0][CordicStages];
    assign w_sq2 = w_ry[1][CordicStages] * w_ry[1][CordicStages];
    assign w_ccp = w_c1 * w_c2;
    assign w_mp  = r_cc * r_t2;
    assign w_sum = (AngW+1)'(r_t1b) + (AngW+1)'(r_m);

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_t1  <= t_ang'(w_sq1 >>> 30);
            r_t2  <= t_ang'(w_sq2 >>> 30);
            r_cc  <= t_ang'(w_ccp >>> 30);
            r_t1b <= r_t1;
            r_m   <= t_ang'(w_mp >>> 30);
            if (w_sum[AngW]) begin
                r_a <= '0;
            end else if (w_sum > (AngW+1)'(OneQ30)) begin
                r_a <= OneQ30;
            end else begin
                r_a <= 31'(w_sum);
            end
        end
    end

    assign w_sn[0][0] = {1'b0, r_a, 30'd0};
    assign w_sn[1][0] = {1'b0, 31'(OneQ30 - r_a), 30'd0};
    assign w_sr[0][0] = '0;
    assign w_sr[1][0] = '0;

    for (genvar s = 0; s < 2; s++) begin : g_sq
        for (genvar k = 0; k < SqrtSteps; k++) begin : g_cell
            hav_sqrt_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_stage(StageW'(k)),
                .i_n    (w_sn[s][k]),
                .i_r    (w_sr[s][k]),
                .o_n    (w_sn[s][k+1]),
                .o_r    (w_sr[s][k+1])
            );
        end
    end

    // atan2(sqrt(a), sqrt(1-a))
    assign w_vy[0] = t_ang'(w_sr[0][SqrtSteps][30:0]);
    assign w_vx[0] = t_ang'(w_sr[1][SqrtSteps][30:0]);
    assign w_vz[0] = '0;

    for (genvar k = 0; k < CordicStages; k++) begin : g_vec
        hav_vec_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_stage(StageW'(k)),
            .i_x    (w_vx[k]),
            .i_y    (w_vy[k]),
            .i_z    (w_vz[k]),
            .o_x    (w_vx[k+1]),
            .o_y    (w_vy[k+1]),
            .o_z    (w_vz[k+1])
        );
    end

    // scale by radius, round and saturate
    assign w_c   = w_vz[CordicStages][AngW-1] ? 32'd0 : {w_vz[CordicStages][30:0], 1'b0};
    assign w_rnd = 63'(r_prod) + RoundHalf;
    assign w_d   = w_rnd[62:30];

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_prod <= 62'(r_rad_cm) * 62'(w_c);
            r_dist <= (w_d > 33'(DistMax)) ? DistMax : 31'(w_d);
        end
    end

endmodule
`default_nettype wire

[rtl/hav_chk.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Haversine distance port checker
// Concurrent checks on the top-level ports, bound to the top level.
// ----------------------------------------------------------------------------
module hav_chk (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        o_s_axis_tready,
    input wire logic        o_m_axis_tvalid,
    input wire logic        i_m_axis_tready,
    input wire logic [31:0] o_m_axis_tdata
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid)
        else $error("result request dropped while stalled");

    a_stall_back: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |-> !o_s_axis_tready)
        else $error("input taken while output stalled");

    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_axis_tvalid)
        else $error("result valid after reset");

    a_top_bit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_m_axis_tdata[31])
        else $error("padding bit set");

endmodule

bind haversine_distance hav_chk u_hav_chk (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_s_axis_tready(o_s_axis_tready),
    .o_m_axis_tvalid(o_m_axis_tvalid),
    .i_m_axis_tready(i_m_axis_tready),
    .o_m_axis_tdata (o_m_axis_tdata)
);
`default_nettype wire
